FILE: sv/rqlt_pkg.sv
// Shared types and constants of the run queue latency tracker.
// Used by the top level and the testbench; depends on nothing.
package rqlt_pkg;

    localparam int PID_W   = 22;
    localparam int CPU_W   = 8;
    localparam int KEY_W   = PID_W + CPU_W;
    localparam int TS_W    = 64;
    localparam int CNT_W   = 32;
    localparam int ENTRY_W = 1 + KEY_W + TS_W + 1 + CNT_W;

    typedef enum logic [1:0] {
        OP_WAKEUP = 2'd0,
        OP_NEW    = 2'd1,
        OP_SWITCH = 2'd2,
        OP_EXIT   = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_END,
        ST_A,
        ST_A_WR,
        ST_B,
        ST_B_WR,
        ST_UPD
    } state_t;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [TS_W-1:0]  wake_time;
        logic             scheduled;
        logic [CNT_W-1:0] count;
    } entry_t;

endpackage

FILE: sv/rqlt_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Stand-alone; used for the task table of the run queue latency tracker.
module rqlt_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/run_queue_latency_tracker_top.sv
// Top level of the run queue latency tracker: control sequencer and totals.
// Depends on rqlt_pkg and rqlt_ram.
//
// The slave channel takes one scheduler event per transaction: tuser carries
// the operation, tdata the timestamp, task id, cpu, previous task id and its
// running flag. The master channel returns exactly one result per event:
// tuser flags a latency sample and a dropped insert, tdata holds the sample
// and the running count, sum, maximum and minimum.
// Each event searches the task table, one entry per cycle through the RAM read
// port, then reads, modifies and writes back at most two entries. The time from
// acceptance to result is set by the associative search over the table memory,
// and a switch that refreshes one entry and then reads back another takes longest.
// One event is in work at a time: a new event is taken only once the last one
// has put its result into the output register.
// After reset the block walks the table and clears it, with s_axis_tready held
// low meanwhile; totals reset to zero.
// A result waits in the output register while the receiver stalls, and the
// next event is already accepted; its result waits until that register frees.
module run_queue_latency_tracker_top #(
    parameter int TABLE_DEPTH = 1024,
    parameter int CPU_COUNT   = 256
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: timestamp, task_pid, cpu, previous task id, prev_running (zero padded).
    input  logic [119:0] s_axis_tdata,
    // tuser: operation.
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: delay, sample count, delay total, largest delay, smallest delay.
    output logic [319:0] m_axis_tdata,
    // tuser: delay_valid, table_full.
    output logic [1:0]   m_axis_tuser
);
    import rqlt_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic [AW:0] LAST = (AW+1)'(TABLE_DEPTH - 1);

    logic [CPU_W-1:0] cpu_mod [256];
    for (genvar g = 0; g < 256; g++) begin : g_mod
        assign cpu_mod[g] = CPU_W'(g % CPU_COUNT);
    end

    state_t state_reg, state_next;
    logic [AW:0]   addr_reg, addr_next;
    logic          cmp_v_reg, cmp_v_next;
    logic [AW-1:0] cmp_addr_reg, cmp_addr_next;

    op_t              op_reg, op_next;
    logic [TS_W-1:0]  ts_reg, ts_next;
    logic [KEY_W-1:0] key_reg, key_next, pkey_reg, pkey_next;
    logic             prun_reg, prun_next;

    logic          hk_reg, hk_next, hp_reg, hp_next, fr_reg, fr_next;
    logic [AW-1:0] hk_idx_reg, hk_idx_next, hp_idx_reg, hp_idx_next;
    logic [AW-1:0] fr_idx_reg, fr_idx_next;
    logic          a_ok_reg, a_ok_next;
    logic [AW-1:0] a_idx_reg, a_idx_next, b_idx_reg, b_idx_next;
    logic          full_reg, full_next, dv_reg, dv_next;
    logic [63:0]   delay_reg, delay_next;

    logic [63:0] tc_reg, tc_next, td_reg, td_next, mx_reg, mx_next, mn_reg, mn_next;

    logic         mv_reg, mv_next;
    logic [319:0] md_reg, md_next;
    logic [1:0]   mu_reg, mu_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    entry_t        wdata, rdata, fresh;
    logic [ENTRY_W-1:0] rdata_raw;

    logic [PID_W-1:0] in_pid, in_ppid;
    logic [CPU_W-1:0] in_cpu;
    logic             stamp, a_hit;
    logic [AW-1:0]    a_slot;
    logic [63:0]      d_sum, d_max, d_min;

    rqlt_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_table (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_raw)
    );
    assign rdata = entry_t'(rdata_raw);

    assign in_pid  = s_axis_tdata[85:64];
    assign in_cpu  = s_axis_tdata[93:86];
    assign in_ppid = s_axis_tdata[115:94];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = mv_reg;
    assign m_axis_tdata  = md_reg;
    assign m_axis_tuser  = mu_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            addr_reg  <= '0;
            cmp_v_reg <= 1'b0;
            mv_reg    <= 1'b0;
            tc_reg    <= '0;
            td_reg    <= '0;
            mx_reg    <= '0;
            mn_reg    <= '0;
        end else begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            cmp_v_reg <= cmp_v_next;
            mv_reg    <= mv_next;
            tc_reg    <= tc_next;
            td_reg    <= td_next;
            mx_reg    <= mx_next;
            mn_reg    <= mn_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmp_addr_reg <= cmp_addr_next;
        op_reg       <= op_next;
        ts_reg       <= ts_next;
        key_reg      <= key_next;
        pkey_reg     <= pkey_next;
        prun_reg     <= prun_next;
        hk_reg       <= hk_next;
        hp_reg       <= hp_next;
        fr_reg       <= fr_next;
        hk_idx_reg   <= hk_idx_next;
        hp_idx_reg   <= hp_idx_next;
        fr_idx_reg   <= fr_idx_next;
        a_ok_reg     <= a_ok_next;
        a_idx_reg    <= a_idx_next;
        b_idx_reg    <= b_idx_next;
        full_reg     <= full_next;
        dv_reg       <= dv_next;
        delay_reg    <= delay_next;
        md_reg       <= md_next;
        mu_reg       <= mu_next;
    end

    assign stamp  = (op_reg == OP_WAKEUP) || ((op_reg == OP_SWITCH) && prun_reg);
    assign a_hit  = (op_reg == OP_WAKEUP) ? hk_reg : hp_reg;
    assign a_slot = (op_reg == OP_WAKEUP) ? hk_idx_reg : hp_idx_reg;
    assign d_sum  = td_reg + delay_reg;
    assign d_max  = (delay_reg > mx_reg) ? delay_reg : mx_reg;
    assign d_min  = ((mn_reg == '0) || (delay_reg < mn_reg)) ? delay_reg : mn_reg;

    always_comb begin
        fresh.valid      = 1'b1;
        fresh.key        = ((op_reg == OP_SWITCH) && prun_reg) ? pkey_reg : key_reg;
        fresh.wake_time  = ts_reg;
        fresh.scheduled  = 1'b0;
        fresh.count      = CNT_W'(1);
    end

    always_comb begin
        state_next    = state_reg;
        addr_next     = addr_reg;
        cmp_v_next    = 1'b0;
        cmp_addr_next = addr_reg[AW-1:0];
        op_next       = op_reg;
        ts_next       = ts_reg;
        key_next      = key_reg;
        pkey_next     = pkey_reg;
        prun_next     = prun_reg;
        hk_next       = hk_reg;
        hp_next       = hp_reg;
        fr_next       = fr_reg;
        hk_idx_next   = hk_idx_reg;
        hp_idx_next   = hp_idx_reg;
        fr_idx_next   = fr_idx_reg;
        a_ok_next     = a_ok_reg;
        a_idx_next    = a_idx_reg;
        b_idx_next    = b_idx_reg;
        full_next     = full_reg;
        dv_next       = dv_reg;
        delay_next    = delay_reg;
        tc_next       = tc_reg;
        td_next       = td_reg;
        mx_next       = mx_reg;
        mn_next       = mn_reg;
        mv_next       = mv_reg && !m_axis_tready;
        md_next       = md_reg;
        mu_next       = mu_reg;
        we            = 1'b0;
        waddr         = addr_reg[AW-1:0];
        wdata         = '0;
        raddr         = addr_reg[AW-1:0];

        if (cmp_v_reg) begin
            if (rdata.valid && (rdata.key == key_reg) && !hk_reg) begin
                hk_next     = 1'b1;
                hk_idx_next = cmp_addr_reg;
            end
            if (rdata.valid && (rdata.key == pkey_reg) && !hp_reg) begin
                hp_next     = 1'b1;
                hp_idx_next = cmp_addr_reg;
            end
            if (!rdata.valid && !fr_reg) begin
                fr_next     = 1'b1;
                fr_idx_next = cmp_addr_reg;
            end
        end

        unique case (state_reg)
            ST_CLEAR: begin
                we        = 1'b1;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == LAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                addr_next = '0;
                if (s_axis_tvalid) begin
                    op_next   = op_t'(s_axis_tuser);
                    ts_next   = s_axis_tdata[63:0];
                    key_next  = (in_pid != '0) ? {{CPU_W{1'b0}}, in_pid}
                                               : {cpu_mod[in_cpu], {PID_W{1'b0}}};
                    pkey_next = (in_ppid != '0) ? {{CPU_W{1'b0}}, in_ppid}
                                                : {cpu_mod[in_cpu], {PID_W{1'b0}}};
                    prun_next = s_axis_tdata[116];
                    hk_next   = 1'b0;
                    hp_next   = 1'b0;
                    fr_next   = 1'b0;
                    a_ok_next = 1'b0;
                    full_next = 1'b0;
                    dv_next   = 1'b0;
                    delay_next = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmp_v_next = 1'b1;
                addr_next  = addr_reg + 1'b1;
                if (addr_reg == LAST) begin
                    state_next = ST_SCAN_END;
                end
            end
            ST_SCAN_END: begin
                state_next = ST_A;
            end
            ST_A: begin
                if (op_reg == OP_NEW) begin
                    if (hk_reg || fr_reg) begin
                        we    = 1'b1;
                        waddr = hk_reg ? hk_idx_reg : fr_idx_reg;
                        wdata = fresh;
                    end else begin
                        full_next = 1'b1;
                    end
                    state_next = ST_UPD;
                end else if (op_reg == OP_EXIT) begin
                    we         = hk_reg;
                    waddr      = hk_idx_reg;
                    state_next = ST_UPD;
                end else if (stamp) begin
                    if (a_hit) begin
                        raddr      = a_slot;
                        a_idx_next = a_slot;
                        a_ok_next  = 1'b1;
                        state_next = ST_A_WR;
                    end else begin
                        if (fr_reg) begin
                            we         = 1'b1;
                            waddr      = fr_idx_reg;
                            wdata      = fresh;
                            a_idx_next = fr_idx_reg;
                            a_ok_next  = 1'b1;
                        end else begin
                            full_next = 1'b1;
                        end
                        state_next = (op_reg == OP_WAKEUP) ? ST_UPD : ST_B;
                    end
                end else begin
                    state_next = ST_B;
                end
            end
            ST_A_WR: begin
                we               = 1'b1;
                waddr            = a_idx_reg;
                wdata            = rdata;
                wdata.wake_time  = ts_reg;
                state_next       = (op_reg == OP_WAKEUP) ? ST_UPD : ST_B;
            end
            ST_B: begin
                if (prun_reg && a_ok_reg && (key_reg == pkey_reg)) begin
                    raddr      = a_idx_reg;
                    b_idx_next = a_idx_reg;
                    state_next = ST_B_WR;
                end else if (hk_reg) begin
                    raddr      = hk_idx_reg;
                    b_idx_next = hk_idx_reg;
                    state_next = ST_B_WR;
                end else begin
                    state_next = ST_UPD;
                end
            end
            ST_B_WR: begin
                we    = 1'b1;
                waddr = b_idx_reg;
                wdata = rdata;
                if (rdata.scheduled) begin
                    wdata.count = rdata.count + 1'b1;
                end else begin
                    wdata.scheduled = 1'b1;
                end
                delay_next = ts_reg - rdata.wake_time;
                dv_next    = 1'b1;
                state_next = ST_UPD;
            end
            ST_UPD: begin
                if (!mv_reg || m_axis_tready) begin
                    if (dv_reg) begin
                        tc_next = tc_reg + 1'b1;
                        td_next = d_sum;
                        mx_next = d_max;
                        mn_next = d_min;
                    end
                    mv_next    = 1'b1;
                    md_next    = {mn_next, mx_next, td_next, tc_next, delay_reg};
                    mu_next    = {full_reg, dv_reg};
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for run_queue_latency_tracker_top with a predicting scoreboard.
// The stimulus covers directed cases, table overflow and random event streams.
// Depends on rqlt_pkg and the RTL of the block.
module tb;
    import rqlt_pkg::*;

    typedef struct {
        op_t         op;
        logic [63:0] ts;
        logic [21:0] pid;
        logic [7:0]  cpu;
        logic [21:0] out_pid;
        logic        prev_run;
    } sched_event_t;

    typedef struct {
        logic        delay_valid;
        logic [63:0] delay;
        logic [63:0] sample_count;
        logic [63:0] delay_total;
        logic [63:0] delay_peak;
        logic [63:0] delay_low;
        logic        table_full;
    } latency_result_t;

    typedef struct {
        logic [63:0] wake_time;
        logic        scheduled;
        logic [31:0] count;
    } task_slot_t;

    localparam int TABLE_DEPTH = 1024;
    localparam int CPU_COUNT   = 256;

    class LatencyScoreboard;
        task_slot_t      tasks[logic [29:0]];
        logic [63:0]     n_samples, delay_sum, delay_max, delay_min;
        latency_result_t pending_q[$];
        int              errors;

        function new();
            n_samples = 0;
            delay_sum = 0;
            delay_max = 0;
            delay_min = 0;
            errors    = 0;
        endfunction

        function logic [29:0] task_key(logic [21:0] pid, logic [7:0] cpu);
            logic [29:0] k;
            if (pid != 0) begin
                k = {8'd0, pid};
            end else begin
                k = 30'(cpu % CPU_COUNT) << PID_W;
            end
            return k;
        endfunction

        // Refreshes a known task or creates it; returns 0 when the insert is dropped.
        function bit stamp(logic [29:0] k, logic [63:0] t);
            task_slot_t s;
            if (tasks.exists(k)) begin
                tasks[k].wake_time = t;
                return 1;
            end
            if (tasks.num() >= TABLE_DEPTH) return 0;
            s.wake_time  = t;
            s.scheduled  = 0;
            s.count      = 1;
            tasks[k] = s;
            return 1;
        endfunction

        function void note_event(sched_event_t e);
            latency_result_t r;
            logic [29:0]     k;
            task_slot_t      s;
            k = task_key(e.pid, e.cpu);
            r.delay_valid = 0;
            r.delay       = 0;
            r.table_full  = 0;
            case (e.op)
                OP_WAKEUP: r.table_full = !stamp(k, e.ts);
                OP_NEW: begin
                    if (tasks.exists(k) || tasks.num() < TABLE_DEPTH) begin
                        s.wake_time  = e.ts;
                        s.scheduled  = 0;
                        s.count      = 1;
                        tasks[k] = s;
                    end else begin
                        r.table_full = 1;
                    end
                end
                OP_SWITCH: begin
                    if (e.prev_run) r.table_full = !stamp(task_key(e.out_pid, e.cpu), e.ts);
                    if (tasks.exists(k)) begin
                        if (tasks[k].scheduled) tasks[k].count = tasks[k].count + 1;
                        else tasks[k].scheduled = 1;
                        r.delay       = e.ts - tasks[k].wake_time;
                        r.delay_valid = 1;
                        n_samples = n_samples + 1;
                        delay_sum = delay_sum + r.delay;
                        if (r.delay > delay_max) delay_max = r.delay;
                        if (delay_min == 0 || r.delay < delay_min) delay_min = r.delay;
                    end
                end
                default: if (tasks.exists(k)) tasks.delete(k);
            endcase
            r.sample_count = n_samples;
            r.delay_total  = delay_sum;
            r.delay_peak   = delay_max;
            r.delay_low    = delay_min;
            pending_q.push_back(r);
        endfunction

        function void cmp(string field, logic [63:0] exp_v, logic [63:0] act_v);
            if (exp_v !== act_v) begin
                errors++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_v, act_v);
            end
        endfunction

        function void check_result(logic [1:0] user, logic [319:0] data);
            latency_result_t r;
            if (pending_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result transaction, actual %h %h", $time, user, data);
                return;
            end
            r = pending_q.pop_front();
            cmp("delay_valid", 64'(r.delay_valid), 64'(user[0]));
            cmp("table_full", 64'(r.table_full), 64'(user[1]));
            cmp("delay", r.delay, data[63:0]);
            cmp("sample_count", r.sample_count, data[127:64]);
            cmp("delay_total", r.delay_total, data[191:128]);
            cmp("delay_peak", r.delay_peak, data[255:192]);
            cmp("delay_low", r.delay_low, data[319:256]);
        endfunction
    endclass

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [119:0] s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = OP_WAKEUP;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [319:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;

    LatencyScoreboard sb = new();
    int               send_idle = 0;
    int               recv_stall = 0;
    int               phase_no = 0;
    logic [63:0]      clock_ns = 64'd1000;
    logic [21:0]      fill_pid;

    run_queue_latency_tracker_top #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .CPU_COUNT  (CPU_COUNT)
    ) DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always begin
        #6 aclk = 1;
        #6 aclk = 0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tuser, m_axis_tdata);
        m_axis_tready <= ($urandom_range(99) >= recv_stall);
    end

    task automatic send(op_t op, logic [63:0] ts, logic [21:0] pid, logic [7:0] cpu,
                        logic [21:0] out_pid, logic prev_run);
        sched_event_t e;
        e = '{op, ts, pid, cpu, out_pid, prev_run};
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {3'd0, prev_run, out_pid, cpu, pid, ts};
        do @(posedge aclk); while (!(s_axis_tvalid && s_axis_tready));
        sb.note_event(e);
    endtask

    // Holds the sender until every expected result has come, then picks the next idling mode.
    task automatic next_phase();
        s_axis_tvalid <= 0;
        @(posedge aclk);
        while (sb.pending_q.size() != 0) @(posedge aclk);
        case (phase_no % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 67; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 67; end
            default: begin send_idle = 30; recv_stall = 30; end
        endcase
        phase_no++;
    endtask

    task automatic random_events(int n);
        op_t         op;
        logic [21:0] pid, ppid;
        logic [63:0] ts;
        for (int i = 0; i < n; i++) begin
            op = op_t'($urandom_range(3));
            pid  = ($urandom_range(9) == 0) ? 22'($urandom) : 22'($urandom_range(12));
            ppid = ($urandom_range(9) == 0) ? 22'($urandom) : 22'($urandom_range(12));
            clock_ns = clock_ns + $urandom_range(5000);
            ts = ($urandom_range(15) == 0) ? {$urandom, $urandom} : clock_ns;
            send(op, ts, pid, 8'($urandom), ppid, 1'($urandom));
        end
    endtask

    initial begin
        #100_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        next_phase();
        send(OP_EXIT, 64'd50, 22'd7, 8'd0, 22'd0, 0);
        send(OP_WAKEUP, 64'd100, 22'd5, 8'd1, 22'd0, 0);
        send(OP_SWITCH, 64'd150, 22'd5, 8'd1, 22'd9, 0);
        send(OP_WAKEUP, 64'd200, 22'd5, 8'd1, 22'd0, 0);
        send(OP_SWITCH, 64'd260, 22'd5, 8'd1, 22'd9, 0);
        send(OP_NEW, 64'd300, 22'd5, 8'd2, 22'd0, 0);
        send(OP_SWITCH, 64'd310, 22'd5, 8'd2, 22'd0, 0);
        send(OP_SWITCH, 64'd320, 22'd123, 8'd2, 22'd5, 1);
        send(OP_WAKEUP, 64'd400, 22'd0, 8'd255, 22'd0, 0);
        send(OP_WAKEUP, 64'd410, 22'd0, 8'd3, 22'd0, 0);
        send(OP_SWITCH, 64'd450, 22'd0, 8'd255, 22'd0, 1);
        send(OP_SWITCH, 64'd470, 22'd0, 8'd3, 22'd5, 1);
        send(OP_NEW, 64'hFFFF_FFFF_FFFF_FFFF, 22'h3FFFFF, 8'd0, 22'd0, 0);
        send(OP_SWITCH, 64'd10, 22'h3FFFFF, 8'd0, 22'h3FFFFF, 0);
        send(OP_SWITCH, 64'd20, 22'd5, 8'd128, 22'h3FFFFF, 1);
        send(OP_SWITCH, 64'd30, 22'h3FFFFF, 8'd127, 22'h2AAAAA, 1);
        send(OP_SWITCH, 64'd1, 22'h155555, 8'd0, 22'h3FFFFF, 0);
        send(OP_EXIT, 64'd40, 22'h3FFFFF, 8'd0, 22'd0, 0);
        send(OP_SWITCH, 64'd50, 22'h3FFFFF, 8'd0, 22'd0, 0);
        send(OP_EXIT, 64'd60, 22'd0, 8'd255, 22'd0, 0);
        send(OP_WAKEUP, 64'd0, 22'd0, 8'd0, 22'd0, 0);
        for (int p = 0; p < 4; p++) begin
            next_phase();
            random_events(90);
        end
        next_phase();
        for (int i = 0; i < 1040; i++) begin
            fill_pid = 22'h200000 + 22'(i);
            clock_ns = clock_ns + $urandom_range(300);
            send(OP_NEW, clock_ns, fill_pid, 8'($urandom), 22'd0, 0);
            if (i % 260 == 259) next_phase();
        end
        send(OP_WAKEUP, clock_ns, 22'h300001, 8'd4, 22'd0, 0);
        send(OP_SWITCH, clock_ns + 5, 22'h200010, 8'd4, 22'h300002, 1);
        send(OP_NEW, clock_ns + 9, 22'h200011, 8'd4, 22'd0, 0);
        for (int i = 0; i < 10; i++) send(OP_EXIT, clock_ns, 22'h200000 + 22'(i), 8'd0, 22'd0, 0);
        for (int p = 0; p < 4; p++) begin
            next_phase();
            random_events(125);
        end
        next_phase();
        repeat (1200) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

FILE: sim.f
sv/rqlt_pkg.sv
sv/rqlt_ram.sv
sv/run_queue_latency_tracker_top.sv
tb/sv/tb.sv
